@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the controller and datapath files.
// ----------------------------------------------------------------------------
// Each macro uses the clock and reset signals of the module that expands it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/swea_pkg.sv @@
// ----------------------------------------------------------------------------
// swea_pkg
// Shared constants and types of the sliding window extreme age block.
// ----------------------------------------------------------------------------
package swea_pkg;

   localparam int WINDOW_DEPTH = 64;
   localparam int PRICE_BITS   = 32;
   localparam int ADDR_BITS    = $clog2(WINDOW_DEPTH);
   localparam int PERIOD_BITS  = 6;
   localparam int AGE_BITS     = 7;
   localparam int RESULT_BITS  = 15;
   localparam int NUM_BITS     = RESULT_BITS + PERIOD_BITS;
   localparam int DIV_STEPS    = RESULT_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(14);
   localparam logic [AGE_BITS-1:0]    AGE_INVALID  = '1;
   // 100.0 in Q13.8
   localparam logic [NUM_BITS-1:0]    SCALE        = NUM_BITS'(25600);

   typedef struct packed {
      logic [PRICE_BITS-1:0] high_price;
      logic [PRICE_BITS-1:0] low_price;
   } req_payload_type;

   typedef struct packed {
      logic [RESULT_BITS-1:0] aroon_up;
      logic [RESULT_BITS-1:0] aroon_down;
      logic                   ready_res;
   } rsp_payload_type;

   typedef struct packed {
      logic accept;
      logic store;
      logic scan;
      logic div_load;
      logic div_step;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic warming;
      logic scan_needed;
      logic scan_done;
      logic div_last;
      logic rsp_free;
   } ctrl_status_type;

endpackage

@@ design/swea_ram.sv @@
// ----------------------------------------------------------------------------
// swea_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swea_ram #(
   parameter int DATA_WIDTH = 64,
   parameter int DEPTH      = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/swea_div.sv @@
// ----------------------------------------------------------------------------
// swea_div
// Restoring divider, one quotient bit per step, for the Q7.8 score.
// ----------------------------------------------------------------------------
module swea_div (
   input  logic                                clock,
   input  logic                                load,
   input  logic                                step,
   input  logic [swea_pkg::NUM_BITS-1:0]       dividend,
   input  logic [swea_pkg::PERIOD_BITS-1:0]    divisor,
   output logic [swea_pkg::RESULT_BITS-1:0]    quotient
);
   import swea_pkg::*;

   logic [PERIOD_BITS-1:0] rem_ff;
   logic [RESULT_BITS-1:0] work_ff;
   logic [PERIOD_BITS:0]   trial;
   logic                   fits;

   // The quotient fits in RESULT_BITS, so the top dividend bits start out
   // already below the divisor and only RESULT_BITS steps are needed.
   assign trial = {rem_ff, work_ff[RESULT_BITS-1]};
   assign fits  = (trial >= {1'b0, divisor});

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff  <= dividend[NUM_BITS-1 -: PERIOD_BITS];
         work_ff <= dividend[RESULT_BITS-1:0];
      end else if (step) begin
         if (fits) begin
            rem_ff <= PERIOD_BITS'(trial - {1'b0, divisor});
         end else begin
            rem_ff <= trial[PERIOD_BITS-1:0];
         end
         work_ff <= {work_ff[RESULT_BITS-2:0], fits};
      end
   end

   assign quotient = work_ff;

endmodule

@@ design/swea_ctrl.sv @@
// ----------------------------------------------------------------------------
// swea_ctrl
// Sequencer: store the sample, rescan if needed, divide unless warming up, hand off the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swea_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  swea_pkg::ctrl_status_type  status,
   output swea_pkg::ctrl_cmd_type     cmd
);
   import swea_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STORE,
      ST_SCAN,
      ST_LOAD,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (status.warming) begin
               state_in = ST_EMIT;
            end else if (status.scan_needed) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   `ASSERT_NEXT(a_accept_then_store, cmd.accept, state_ff == ST_STORE)

endmodule

@@ design/swea_dp.sv @@
// ----------------------------------------------------------------------------
// swea_dp
// Datapath: sample window, extreme tracking, rescan, dividers, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swea_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [swea_pkg::PERIOD_BITS-1:0]    csr_wdata,
   input  swea_pkg::req_payload_type           req_data,
   input  swea_pkg::ctrl_cmd_type              cmd,
   output swea_pkg::ctrl_status_type           status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output swea_pkg::rsp_payload_type           rsp_data
);
   import swea_pkg::*;

   logic [PERIOD_BITS-1:0] period_ff;
   logic [PERIOD_BITS-1:0] p;
   logic [AGE_BITS-1:0]    p_age;

   req_payload_type        sample_ff;
   logic [ADDR_BITS-1:0]   wp_ff;
   logic [ADDR_BITS-1:0]   newest_ff;
   logic [AGE_BITS-1:0]    warmup_ff;
   logic                   zero_ff;

   logic [PRICE_BITS-1:0]  hi_val_ff, lo_val_ff;
   logic [AGE_BITS-1:0]    hi_age_ff, lo_age_ff;
   logic [AGE_BITS-1:0]    hi_age_in, lo_age_in;
   logic                   hi_scan_ff, lo_scan_ff;
   logic                   warming;

   logic                   issue_active_ff;
   logic [PERIOD_BITS-1:0] issue_age_ff;
   logic                   rd_valid_ff;
   logic [PERIOD_BITS-1:0] rd_age_ff;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic [2*PRICE_BITS-1:0] rd_data;
   logic [PRICE_BITS-1:0]  rd_hi, rd_lo;
   logic                   rd_first;

   logic [DIV_CNT_BITS-1:0] div_cnt_ff;
   logic [PERIOD_BITS-1:0]  hi_dist, lo_dist;
   logic [NUM_BITS-1:0]     hi_num, lo_num;
   logic [RESULT_BITS-1:0]  up_q, down_q;

   logic                   rsp_valid_ff;
   rsp_payload_type        rsp_data_ff;

   // A period of zero acts as one.
   assign p     = (period_ff == '0) ? PERIOD_BITS'(1) : period_ff;
   assign p_age = {1'b0, p};

   // Ages count up each item while valid; the invalid code stays put.
   assign hi_age_in = (hi_age_ff == AGE_INVALID) ? AGE_INVALID : AGE_BITS'(hi_age_ff + 1'b1);
   assign lo_age_in = (lo_age_ff == AGE_INVALID) ? AGE_INVALID : AGE_BITS'(lo_age_ff + 1'b1);
   assign warming   = (warmup_ff < p_age);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_data;
      end
      if (cmd.store) begin
         newest_ff    <= wp_ff;
         issue_age_ff <= p;
         zero_ff      <= warming;
      end
      if (issue_active_ff) begin
         issue_age_ff <= issue_age_ff - 1'b1;
      end
      rd_age_ff <= issue_age_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         if (reset) begin
            period_ff <= PERIOD_RESET;
         end else begin
            period_ff <= csr_wdata;
         end
         wp_ff      <= '0;
         warmup_ff  <= '0;
         hi_val_ff  <= '0;
         lo_val_ff  <= '0;
         hi_age_ff  <= AGE_INVALID;
         lo_age_ff  <= AGE_INVALID;
         hi_scan_ff <= 1'b0;
         lo_scan_ff <= 1'b0;
      end else if (cmd.store) begin
         wp_ff <= wp_ff + 1'b1;
         if (warming) begin
            warmup_ff  <= warmup_ff + 1'b1;
            hi_age_ff  <= hi_age_in;
            lo_age_ff  <= lo_age_in;
            hi_scan_ff <= 1'b0;
            lo_scan_ff <= 1'b0;
         end else begin
            hi_scan_ff <= (hi_age_in > p_age);
            lo_scan_ff <= (lo_age_in > p_age);
            if (hi_age_in > p_age) begin
               hi_age_ff <= p_age;
            end else if (sample_ff.high_price >= hi_val_ff) begin
               hi_val_ff <= sample_ff.high_price;
               hi_age_ff <= '0;
            end else begin
               hi_age_ff <= hi_age_in;
            end
            if (lo_age_in > p_age) begin
               lo_age_ff <= p_age;
            end else if (sample_ff.low_price <= lo_val_ff) begin
               lo_val_ff <= sample_ff.low_price;
               lo_age_ff <= '0;
            end else begin
               lo_age_ff <= lo_age_in;
            end
         end
      end else if (rd_valid_ff) begin
         // Rescan runs oldest to newest; the oldest entry seeds the extreme
         // and later ties win.
         if (hi_scan_ff && (rd_first || (rd_hi >= hi_val_ff))) begin
            hi_val_ff <= rd_hi;
            hi_age_ff <= {1'b0, rd_age_ff};
         end
         if (lo_scan_ff && (rd_first || (rd_lo <= lo_val_ff))) begin
            lo_val_ff <= rd_lo;
            lo_age_ff <= {1'b0, rd_age_ff};
         end
      end
   end

   // Rescan read pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_active_ff <= 1'b0;
         rd_valid_ff     <= 1'b0;
      end else begin
         if (cmd.store) begin
            issue_active_ff <= !warming && ((hi_age_in > p_age) || (lo_age_in > p_age));
         end else if (issue_active_ff && (issue_age_ff == '0)) begin
            issue_active_ff <= 1'b0;
         end
         rd_valid_ff <= issue_active_ff;
      end
   end

   assign rd_addr  = ADDR_BITS'(newest_ff - issue_age_ff);
   assign rd_hi    = rd_data[2*PRICE_BITS-1:PRICE_BITS];
   assign rd_lo    = rd_data[PRICE_BITS-1:0];
   assign rd_first = (rd_age_ff == p);

   swea_ram #(
      .DATA_WIDTH (2*PRICE_BITS),
      .DEPTH      (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (wp_ff),
      .wr_data ({sample_ff.high_price, sample_ff.low_price}),
      .rd_en   (issue_active_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Score numerators: 25600 * (period - age), age clamped to the period.
   assign hi_dist = (hi_age_ff > p_age) ? '0 : PERIOD_BITS'(p - hi_age_ff[PERIOD_BITS-1:0]);
   assign lo_dist = (lo_age_ff > p_age) ? '0 : PERIOD_BITS'(p - lo_age_ff[PERIOD_BITS-1:0]);
   assign hi_num  = NUM_BITS'(NUM_BITS'(hi_dist) * SCALE);
   assign lo_num  = NUM_BITS'(NUM_BITS'(lo_dist) * SCALE);

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   swea_div u_div_up (
      .clock    (clock),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .dividend (hi_num),
      .divisor  (p),
      .quotient (up_q)
   );

   swea_div u_div_down (
      .clock    (clock),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .dividend (lo_num),
      .divisor  (p),
      .quotient (down_q)
   );

   // Output register: a finished result waits here while the next item
   // is taken in.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (zero_ff) begin
            rsp_data_ff <= '0;
         end else begin
            rsp_data_ff.aroon_up   <= up_q;
            rsp_data_ff.aroon_down <= down_q;
            rsp_data_ff.ready_res  <= 1'b1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.warming     = warming;
   assign status.scan_needed = !warming && ((hi_age_in > p_age) || (lo_age_in > p_age));
   assign status.scan_done   = !issue_active_ff && !rd_valid_ff;
   assign status.div_last    = (div_cnt_ff == DIV_CNT_BITS'(DIV_STEPS - 1));
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

   `ASSERT_NEXT(a_age_in_window, cmd.store && !warming, (hi_age_ff <= p_age) && (lo_age_ff <= p_age))
   `ASSERT_IMPLIES(a_scan_has_lane, rd_valid_ff, hi_scan_ff || lo_scan_ff)
   `ASSERT_NEXT(a_score_range, cmd.emit && !zero_ff, rsp_data_ff.aroon_up <= RESULT_BITS'(SCALE))

endmodule

@@ design/sliding_window_extreme_age.sv @@
// ----------------------------------------------------------------------------
// sliding_window_extreme_age
// Aroon up/down scores over a sliding window of high/low samples.
//
//   Channel | Ports                         | Carries
//   --------+-------------------------------+-----------------------------
//   request | req_valid req_ready req_data  | one high/low sample
//   result  | rsp_valid rsp_ready rsp_data  | aroon_up, aroon_down, ready_res
//   csr     | csr_we csr_wdata              | period (write clears state)
//
// An item passes idle, store and emit during warm-up, and idle, store, load,
// divide and emit when the tracked extremes stay in the window; a rescan adds
// a scan state before load, one window read per cycle from the oldest entry to
// the newest. The two 15-step dividers run side by side in the divide state.
// Reset is synchronous; it sets the period to 14 and clears the window state.
// A result waits in the output register while the next item is taken in;
// the item after that waits until the register is free.
// ----------------------------------------------------------------------------
module sliding_window_extreme_age (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  swea_pkg::req_payload_type         req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output swea_pkg::rsp_payload_type         rsp_data,
   input  logic                              csr_we,
   input  logic [swea_pkg::PERIOD_BITS-1:0]  csr_wdata
);
   import swea_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   swea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   swea_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the Aroon up/down scores of sliding_window_extreme_age. A
// cycle-accurate-free predictor mirrors the window, the warm-up count and the
// tracked extremes, and each result transfer is compared field by field with
// the oldest predicted score. Stimulus runs through several period settings,
// with random idling on both channels, one long result stall and drains between phases.
// ----------------------------------------------------------------------------
module testbench;
   import swea_pkg::*;

   localparam int unsigned Q88_HUNDRED   = 25600;
   localparam int unsigned SETTLE_CYCLES = 120;
   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned MAX_PRINTED   = 100;

   typedef enum int {NOISE, TIES, RISING, FALLING, CORNERS} price_pattern_type;

   class aroon_tracker;
      logic [PRICE_BITS-1:0] high_hist [WINDOW_DEPTH];
      logic [PRICE_BITS-1:0] low_hist [WINDOW_DEPTH];
      logic [PRICE_BITS-1:0] top_value;
      logic [PRICE_BITS-1:0] bottom_value;
      int unsigned           next_slot;
      int unsigned           samples_seen;
      int unsigned           top_age;
      int unsigned           bottom_age;
      int unsigned           period_reg;
      rsp_payload_type       expected_scores [$];
      int unsigned           error_count;

      function new();
         period_reg  = PERIOD_RESET;
         error_count = 0;
         clear();
      endfunction

      function void clear();
         foreach (high_hist[i]) begin
            high_hist[i] = '0;
            low_hist[i]  = '0;
         end
         next_slot    = 0;
         samples_seen = 0;
         top_value    = '0;
         bottom_value = '0;
         top_age      = AGE_INVALID;
         bottom_age   = AGE_INVALID;
      endfunction

      function void set_period(input logic [PERIOD_BITS-1:0] value);
         period_reg = value;
         clear();
      endfunction

      function int unsigned span();
         int unsigned p;
         p = period_reg;
         if (p == 0) p = 1;
         if (p > WINDOW_DEPTH - 1) p = WINDOW_DEPTH - 1;
         return p;
      endfunction

      function int unsigned slot_back(input int unsigned newest, input int unsigned age);
         return (newest + WINDOW_DEPTH - age) % WINDOW_DEPTH;
      endfunction

      function logic [RESULT_BITS-1:0] score(input int unsigned p, input int unsigned age);
         int unsigned a;
         a = (age > p) ? p : age;
         return RESULT_BITS'((Q88_HUNDRED * (p - a)) / p);
      endfunction

      function int unsigned pending();
         return expected_scores.size();
      endfunction

      function void note_sample(input req_payload_type s);
         int unsigned           p;
         int unsigned           newest;
         int                    k;
         logic [PRICE_BITS-1:0] v;
         rsp_payload_type       r;
         p      = span();
         newest = next_slot;
         high_hist[newest] = s.high_price;
         low_hist[newest]  = s.low_price;
         next_slot = (newest + 1) % WINDOW_DEPTH;
         if (top_age != AGE_INVALID) top_age++;
         if (bottom_age != AGE_INVALID) bottom_age++;
         r = '0;
         if (samples_seen < p) begin
            samples_seen++;
            expected_scores.push_back(r);
            return;
         end
         // An invalid or aged-out extreme is found again by scanning from the
         // oldest sample to the newest, so that ties end on the newest one.
         if (top_age > p) begin
            top_age   = p;
            top_value = high_hist[slot_back(newest, p)];
            for (k = int'(p) - 1; k >= 0; k--) begin
               v = high_hist[slot_back(newest, k)];
               if (v >= top_value) begin
                  top_value = v;
                  top_age   = k;
               end
            end
         end else if (s.high_price >= top_value) begin
            top_value = s.high_price;
            top_age   = 0;
         end
         if (bottom_age > p) begin
            bottom_age   = p;
            bottom_value = low_hist[slot_back(newest, p)];
            for (k = int'(p) - 1; k >= 0; k--) begin
               v = low_hist[slot_back(newest, k)];
               if (v <= bottom_value) begin
                  bottom_value = v;
                  bottom_age   = k;
               end
            end
         end else if (s.low_price <= bottom_value) begin
            bottom_value = s.low_price;
            bottom_age   = 0;
         end
         r.aroon_up   = score(p, top_age);
         r.aroon_down = score(p, bottom_age);
         r.ready_res  = 1'b1;
         expected_scores.push_back(r);
      endfunction

      task report_mismatch(input string msg);
         if (error_count < MAX_PRINTED) $display("mismatch: %s", msg);
         error_count++;
      endtask

      task check_score(input rsp_payload_type got);
         rsp_payload_type want;
         if (expected_scores.size() == 0) begin
            report_mismatch($sformatf("result with no expectation up=%0d down=%0d",
                                      got.aroon_up, got.aroon_down));
            return;
         end
         want = expected_scores.pop_front();
         if (got.aroon_up !== want.aroon_up)
            report_mismatch($sformatf("aroon_up got %0d want %0d",
                                      got.aroon_up, want.aroon_up));
         if (got.aroon_down !== want.aroon_down)
            report_mismatch($sformatf("aroon_down got %0d want %0d",
                                      got.aroon_down, want.aroon_down));
         if (got.ready_res !== want.ready_res)
            report_mismatch($sformatf("ready_res got %0b want %0b",
                                      got.ready_res, want.ready_res));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_payload_type        req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_we = 1'b0;
   logic [PERIOD_BITS-1:0] csr_wdata = '0;

   aroon_tracker tracker = new();
   int unsigned  cycle_count = 0;
   int unsigned  long_hold_cycles = 0;
   bit           no_idle = 1'b0;

   sliding_window_extreme_age uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tracker.note_sample(req_data);
         if (rsp_valid && rsp_ready) tracker.check_score(rsp_data);
      end
   end

   // Result side: random stalls, plus one long hold-off when asked for.
   initial begin : result_sink
      int unsigned n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_cycles != 0) begin
            n = long_hold_cycles;
            long_hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Holds one sample until its transfer; on return valid is high, or low after a random idle.
   task automatic offer(input logic [PRICE_BITS-1:0] hi, input logic [PRICE_BITS-1:0] lo);
      req_valid <= 1'b1;
      req_data  <= '{high_price: hi, low_price: lo};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // The task waits for a clock edge first so that the last accepted sample has been noted.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_period(input logic [PERIOD_BITS-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_period(value);
   endtask

   task automatic random_samples(input int unsigned count);
      int unsigned           k;
      int unsigned           run_left;
      price_pattern_type     pattern;
      logic [PRICE_BITS-1:0] hi;
      logic [PRICE_BITS-1:0] lo;
      run_left = 0;
      pattern  = NOISE;
      hi = $urandom();
      lo = $urandom();
      for (k = 0; k < count; k++) begin
         if (run_left == 0) begin
            pattern  = price_pattern_type'($urandom_range(0, 4));
            run_left = $urandom_range(4, 20);
         end
         run_left--;
         case (pattern)
            NOISE: begin
               hi = $urandom();
               lo = $urandom();
            end
            TIES: begin
               hi = $urandom_range(0, 3);
               lo = $urandom_range(0, 3);
            end
            // A rising high keeps the newest sample on top; a falling high keeps the top
            // on the oldest sample, save where samples tie, so it ages out and forces a rescan.
            RISING: begin
               hi = hi + $urandom_range(0, 5);
               lo = lo + $urandom_range(0, 5);
            end
            FALLING: begin
               hi = hi - $urandom_range(0, 5);
               lo = lo - $urandom_range(0, 5);
            end
            default: begin
               hi = $urandom_range(0, 1) ? '1 : '0;
               lo = $urandom_range(0, 1) ? '1 : '0;
            end
         endcase
         offer(hi, lo);
      end
   endtask

   initial begin : stimulus
      int unsigned           i;
      logic [PERIOD_BITS-1:0] p;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset period of 14: warm-up, first scan, extreme aging out, ties.
      offer('1, '0);
      for (i = 1; i < 14; i++) offer(PRICE_BITS'(i), ~PRICE_BITS'(i));
      offer(32'd1, 32'hFFFF_FFF0);
      offer('0, '1);
      offer(32'd13, ~PRICE_BITS'(13));
      offer('1, '0);

      // Period zero acts as period one.
      write_period(6'd0);
      offer(32'd7, 32'd7);
      offer(32'd7, 32'd7);
      offer(32'd7, 32'd7);
      offer(32'd9, 32'd3);
      offer('0, '1);

      write_period(6'd1);
      random_samples(40);

      write_period(6'd63);
      random_samples(110);

      // Long result stall while samples keep coming, so the input backs up.
      write_period(6'd2);
      long_hold_cycles = 400;
      random_samples(40);

      write_period(6'd3);
      random_samples(20);
      drain();
      random_samples(20);

      p = PERIOD_BITS'($urandom_range(0, 63));
      write_period(p);
      random_samples(int'(p) + 30);

      write_period(6'd5);
      random_samples(40);

      p = PERIOD_BITS'($urandom_range(0, 63));
      write_period(p);
      random_samples(int'(p) + 30);

      write_period(6'd14);
      no_idle = 1'b1;
      random_samples(40);

      drain();
      if (tracker.error_count == 0 && tracker.pending() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
